FILE: sv/parametrized_crc_engine_defines.svh
// assertion macros shared by the crc engine rtl
// no dependencies; included by the files that carry assertions
`ifndef PARAMETRIZED_CRC_ENGINE_DEFINES_SVH
`define PARAMETRIZED_CRC_ENGINE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define PCRC_ASSERT_SAME(lbl, ck, rs, ante, cons, txt) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(txt);

// condition holds in the cycle after the trigger
`define PCRC_ASSERT_NEXT(lbl, ck, rs, ante, cons, txt) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(txt);

`endif

FILE: sv/pcrc_pkg.sv
// shared types, constants and helpers for the crc engine
// no dependencies; used by pcrc_cfg_if and all modules
package pcrc_pkg;

  localparam int MaxWidthDefault = 32;
  localparam int CrcMinWidth     = 8;
  localparam int CfgIdxWidth     = 3;
  localparam int CfgDataWidth    = 32;

  localparam logic [5:0]  CrcWidthReset = 6'd32;
  localparam logic [31:0] PolyReset     = 32'hEE5B42FD;
  localparam logic [31:0] StartReset    = 32'h0000_0000;
  localparam logic [31:0] FinalXorReset = 32'h0000_0000;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegCrcWidth      = 3'd0,
    RegPolynomial    = 3'd1,
    RegStartValue    = 3'd2,
    RegReflectInput  = 3'd3,
    RegReflectOutput = 3'd4,
    RegFinalXor      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [5:0]  crc_width;
    logic [31:0] polynomial;
    logic [31:0] start_value;
    logic        reflect_input;
    logic        reflect_output;
    logic [31:0] final_xor_value;
  } cfg_t;

  function automatic logic [7:0] reverse_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage

FILE: sv/pcrc_in_if.sv
// message item channel: one byte, byte-present flag and end-of-message mark
// depends on nothing
interface pcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last, output ready);
endinterface

FILE: sv/pcrc_out_if.sv
// result channel carrying the finished crc
// depends on nothing
interface pcrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

FILE: sv/pcrc_cfg_if.sv
// configuration write channel: register index and write data
// depends on pcrc_pkg for the field widths
interface pcrc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pcrc_pkg::CfgIdxWidth-1:0]    index;
  logic [pcrc_pkg::CfgDataWidth-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/pcrc_cfg_regs.sv
// configuration register file of the crc engine
// depends on pcrc_pkg and pcrc_cfg_if
module pcrc_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  pcrc_cfg_if.sink         cfg,
  output pcrc_pkg::cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.crc_width       <= pcrc_pkg::CrcWidthReset;
      regs.polynomial      <= pcrc_pkg::PolyReset;
      regs.start_value     <= pcrc_pkg::StartReset;
      regs.reflect_input   <= 1'b0;
      regs.reflect_output  <= 1'b0;
      regs.final_xor_value <= pcrc_pkg::FinalXorReset;
    end else if (cfg.valid) begin
      // indexes past the list are dropped
      unique case (pcrc_pkg::reg_idx_t'(cfg.index))
        pcrc_pkg::RegCrcWidth:      regs.crc_width       <= cfg.data[5:0];
        pcrc_pkg::RegPolynomial:    regs.polynomial      <= cfg.data[31:0];
        pcrc_pkg::RegStartValue:    regs.start_value     <= cfg.data[31:0];
        pcrc_pkg::RegReflectInput:  regs.reflect_input   <= cfg.data[0];
        pcrc_pkg::RegReflectOutput: regs.reflect_output  <= cfg.data[0];
        pcrc_pkg::RegFinalXor:      regs.final_xor_value <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/pcrc_step.sv
// one-byte crc update and message finish, purely combinational
// depends on pcrc_pkg
module pcrc_step #(
  parameter int MAX_WIDTH = pcrc_pkg::MaxWidthDefault
) (
  input  pcrc_pkg::cfg_t          cfg,
  input  logic [MAX_WIDTH-1:0]    running_crc,
  input  logic                    mid_message,
  input  logic [7:0]              data_byte,
  input  logic                    has_byte,
  output logic [MAX_WIDTH-1:0]    crc_next,
  output logic [31:0]             crc_result
);

  localparam logic [6:0] MaxW = 7'(MAX_WIDTH);

  logic [6:0]           cw;
  logic [6:0]           eff_w;
  logic [6:0]           shift;
  logic [MAX_WIDTH-1:0] mask;
  logic [MAX_WIDTH-1:0] poly_lj;
  logic [MAX_WIDTH-1:0] start_crc;
  logic [MAX_WIDTH-1:0] lj_in;
  logic [MAX_WIDTH-1:0] lj_out;
  logic [MAX_WIDTH-1:0] lj_rev;
  logic [MAX_WIDTH-1:0] fin;
  logic [MAX_WIDTH-1:0] res;
  logic [63:0]          res_ext;
  logic [7:0]           b;

  always_comb begin
    cw = {1'b0, cfg.crc_width};
    if (cw < 7'(pcrc_pkg::CrcMinWidth)) begin
      eff_w = 7'(pcrc_pkg::CrcMinWidth);
    end else if (cw > MaxW) begin
      eff_w = MaxW;
    end else begin
      eff_w = cw;
    end
    shift = MaxW - eff_w;
  end

  // the crc is worked left-justified so the feedback tap is always the msb
  assign mask      = {MAX_WIDTH{1'b1}} >> shift;
  assign poly_lj   = (MAX_WIDTH'(cfg.polynomial) & mask) << shift;
  assign start_crc = mid_message ? running_crc : MAX_WIDTH'(cfg.start_value);
  assign lj_in     = (start_crc & mask) << shift;
  assign b         = cfg.reflect_input ? pcrc_pkg::reverse_byte(data_byte) : data_byte;

  always_comb begin
    lj_out = lj_in;
    if (has_byte) begin
      for (int i = 7; i >= 0; i--) begin
        if (lj_out[MAX_WIDTH-1] ^ b[i]) begin
          lj_out = (lj_out << 1) ^ poly_lj;
        end else begin
          lj_out = lj_out << 1;
        end
      end
    end
  end

  // full reversal of the left-justified value mirrors exactly the active bits
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      lj_rev[i] = lj_out[MAX_WIDTH-1-i];
    end
  end

  assign crc_next   = lj_out >> shift;
  assign fin        = cfg.reflect_output ? lj_rev : crc_next;
  assign res        = (fin ^ MAX_WIDTH'(cfg.final_xor_value)) & mask;
  assign res_ext    = 64'(res);
  assign crc_result = res_ext[31:0];

endmodule

FILE: sv/parametrized_crc_engine.sv
// Configurable crc engine (width 8 to MAX_WIDTH bits, polynomial, start value, input and
// output reflection, final xor). One message byte per item, one item per clock unless
// stalled; the finished crc enters the result register as the closing item leaves the input
// register. An item first lands in an input register, then the byte update (eight xor/shift
// steps) runs from that register into the running crc and result registers; that update
// path sets the clock rate. Items without a last mark keep flowing while a finished crc
// waits to be taken; a closing item waits in the input register until the result slot frees,
// which stalls the input. Settings are read live, so write them between messages.
// depends on pcrc_pkg, the pcrc interfaces, pcrc_cfg_regs, pcrc_step and the defines header
`include "parametrized_crc_engine_defines.svh"

module parametrized_crc_engine #(
  parameter int MAX_WIDTH = pcrc_pkg::MaxWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  pcrc_in_if.sink     msg,
  pcrc_out_if.source  crc,
  pcrc_cfg_if.sink    cfg
);

  pcrc_pkg::cfg_t        regs;

  logic                  stg_valid;
  logic [7:0]            stg_byte;
  logic                  stg_has;
  logic                  stg_last;
  logic                  adv;

  logic [MAX_WIDTH-1:0]  running_crc;
  logic                  mid_message;
  logic [MAX_WIDTH-1:0]  crc_next;
  logic [31:0]           crc_result;

  logic                  out_valid;
  logic [31:0]           out_crc;

  pcrc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  pcrc_step #(.MAX_WIDTH(MAX_WIDTH)) u_step (
    .cfg         (regs),
    .running_crc (running_crc),
    .mid_message (mid_message),
    .data_byte   (stg_byte),
    .has_byte    (stg_has),
    .crc_next    (crc_next),
    .crc_result  (crc_result)
  );

  // an item that closes a message needs a free result slot
  assign adv       = stg_valid && (!stg_last || !out_valid || crc.ready);
  assign msg.ready = !stg_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (msg.valid && msg.ready) begin
      stg_valid <= 1'b1;
    end else if (adv) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      stg_byte <= msg.data_byte;
      stg_has  <= msg.has_byte;
      stg_last <= msg.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
      mid_message <= 1'b0;
    end else if (adv && (stg_has || stg_last)) begin
      running_crc <= stg_last ? '0 : crc_next;
      mid_message <= !stg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && stg_last) begin
      out_valid <= 1'b1;
    end else if (crc.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && stg_last) begin
      out_crc <= crc_result;
    end
  end

  assign crc.valid     = out_valid;
  assign crc.crc_value = out_crc;

  `PCRC_ASSERT_SAME(a_stall_needs_item, clk, rst, !msg.ready, stg_valid,
                    "input stalled with empty input register")
  `PCRC_ASSERT_NEXT(a_last_makes_result, clk, rst, adv && stg_last, out_valid,
                    "closing item gave no result")
  `PCRC_ASSERT_NEXT(a_last_closes_msg, clk, rst, adv && stg_last, !mid_message,
                    "message still open after closing item")
  `PCRC_ASSERT_NEXT(a_byte_opens_msg, clk, rst, adv && stg_has && !stg_last, mid_message,
                    "byte item left no open message")
  `PCRC_ASSERT_SAME(a_no_overwrite, clk, rst,
                    out_valid && !crc.ready && stg_valid && stg_last, !adv,
                    "waiting result would be overwritten")

endmodule
